// File: rtl/core/lrupr_pkg.sv
package lrupr_pkg;

   // Slot numbering: the slot index field is six bits wide, so every code names a slot.
   localparam int SLOT_W     = 6;
   localparam int SLOT_COUNT = 1 << SLOT_W;

   // Tag width and the pattern that marks an unbound slot.
   localparam int TAG_W = 16;
   localparam logic [TAG_W-1:0] TAG_UNBOUND = {TAG_W{1'b1}};

   // Request codes.
   localparam logic REQ_TOUCH  = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

endpackage

// File: rtl/core/lru_page_replacement_unit.sv
// LRU page replacement unit.
// Input channel (req_*): a word carries a request type, a slot index and two tags.
// A touch moves the named slot to the most recent end and returns nothing. An insert
// evicts the least recent slot, returns its index and old tags on the rsp_* channel,
// binds the new tags to it and makes it most recent.
// Both channels take a word at a clock edge with valid high and stall low.
// Each request passes an accepting step that reads both link memories and the tag memory,
// then a link step and a relink step that write the links back, since each link memory
// has a single write port and a move can need two writes to each of them.
// An insert shows its result as it leaves the link step; rsp_valid holds with its word
// while rsp_stall is high, and a following insert waits in its link step until the
// output register is free. A touch goes on while an earlier result waits.
// Synchronous reset makes slot 0 least recent and the last slot most recent, with all
// tags unbound. Per-entry valid bits stand in for the reset contents of the memories,
// so the unit takes requests as soon as reset ends, with no clearing pass.
module lru_page_replacement_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic        [lrupr_pkg::SLOT_W-1:0]    req_slot_index,
   input  logic signed [lrupr_pkg::TAG_W-1:0]     req_new_cluster,
   input  logic signed [lrupr_pkg::TAG_W-1:0]     req_new_local_page,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [lrupr_pkg::SLOT_W-1:0]    rsp_victim_slot,
   output logic signed [lrupr_pkg::TAG_W-1:0]     rsp_old_cluster,
   output logic signed [lrupr_pkg::TAG_W-1:0]     rsp_old_local_page
);
   import lrupr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LINK,
      ST_RELINK
   } state_type;

   typedef logic [SLOT_W-1:0] slot_type;

   state_type state_ff, state_in;

   // List ends.
   slot_type mru_ff, mru_in;
   slot_type lru_ff, lru_in;

   // Captured request.
   slot_type          slot_ff;
   logic              ins_ff;
   logic [TAG_W-1:0]  new_cl_ff;
   logic [TAG_W-1:0]  new_pg_ff;

   // Link and tag memories with their valid bits.
   slot_type           lru_link_mem [SLOT_COUNT];
   slot_type           mru_link_mem [SLOT_COUNT];
   logic [2*TAG_W-1:0] tag_mem      [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] lru_vld_ff;
   logic [SLOT_COUNT-1:0] mru_vld_ff;
   logic [SLOT_COUNT-1:0] tag_vld_ff;

   // Registered read data.
   slot_type           older_rd_ff;
   slot_type           newer_rd_ff;
   logic [2*TAG_W-1:0] tag_rd_ff;
   logic               older_vld_ff;
   logic               newer_vld_ff;
   logic               tag_vld_rd_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   slot_type           rsp_slot_ff;
   logic [2*TAG_W-1:0] rsp_tag_ff;

   logic     req_accept;
   slot_type rd_addr;
   slot_type older;
   slot_type newer;
   logic     move;
   logic     link_go;
   logic     rsp_load;

   logic               lru_we, mru_we, tag_we;
   slot_type           lru_waddr, mru_waddr;
   slot_type           lru_wdata, mru_wdata;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // An insert always works on the least recent slot.
   assign rd_addr = (req_type == REQ_INSERT) ? lru_ff : req_slot_index;

   // Entries never written read as their reset links.
   assign older = older_vld_ff ? older_rd_ff : slot_ff - slot_type'(1);
   assign newer = newer_vld_ff ? newer_rd_ff : slot_ff + slot_type'(1);

   // The most recent slot does not move.
   assign move = (slot_ff != mru_ff);

   // An insert holds in the link step until the output register is free.
   assign link_go  = !(ins_ff && rsp_valid_ff && rsp_stall);
   assign rsp_load = (state_ff == ST_LINK) && ins_ff && link_go;

   // Memory write ports and next state.
   always_comb begin
      state_in     = state_ff;
      mru_in       = mru_ff;
      lru_in       = lru_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lru_we       = 1'b0;
      mru_we       = 1'b0;
      tag_we       = 1'b0;
      lru_waddr    = slot_ff;
      lru_wdata    = mru_ff;
      mru_waddr    = mru_ff;
      mru_wdata    = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            if (link_go) begin
               // Hook the slot behind the current most recent slot.
               lru_we   = move;
               mru_we   = move;
               tag_we   = ins_ff;
               state_in = ST_RELINK;
               if (ins_ff) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_RELINK: begin
            // Close the gap the slot leaves behind.
            lru_waddr = newer;
            lru_wdata = older;
            mru_waddr = older;
            mru_wdata = newer;
            lru_we    = move;
            mru_we    = move && (slot_ff != lru_ff);
            if (move) begin
               mru_in = slot_ff;
               if (slot_ff == lru_ff) begin
                  lru_in = newer;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mru_ff       <= slot_type'(SLOT_COUNT - 1);
         lru_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mru_ff       <= mru_in;
         lru_ff       <= lru_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture and result word.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_ff   <= rd_addr;
         ins_ff    <= (req_type == REQ_INSERT);
         new_cl_ff <= req_new_cluster;
         new_pg_ff <= req_new_local_page;
      end
      if (rsp_load) begin
         rsp_slot_ff <= slot_ff;
         rsp_tag_ff  <= tag_vld_rd_ff ? tag_rd_ff : {TAG_UNBOUND, TAG_UNBOUND};
      end
   end

   // Memory reads and writes.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         older_rd_ff   <= lru_link_mem[rd_addr];
         newer_rd_ff   <= mru_link_mem[rd_addr];
         tag_rd_ff     <= tag_mem[rd_addr];
         older_vld_ff  <= lru_vld_ff[rd_addr];
         newer_vld_ff  <= mru_vld_ff[rd_addr];
         tag_vld_rd_ff <= tag_vld_ff[rd_addr];
      end
      if (lru_we) begin
         lru_link_mem[lru_waddr] <= lru_wdata;
      end
      if (mru_we) begin
         mru_link_mem[mru_waddr] <= mru_wdata;
      end
      if (tag_we) begin
         tag_mem[slot_ff] <= {new_cl_ff, new_pg_ff};
      end
   end

   // Valid bits mark entries written since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         lru_vld_ff <= '0;
         mru_vld_ff <= '0;
         tag_vld_ff <= '0;
      end else begin
         if (lru_we) begin
            lru_vld_ff[lru_waddr] <= 1'b1;
         end
         if (mru_we) begin
            mru_vld_ff[mru_waddr] <= 1'b1;
         end
         if (tag_we) begin
            tag_vld_ff[slot_ff] <= 1'b1;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_victim_slot    = rsp_slot_ff;
   assign rsp_old_cluster    = rsp_tag_ff[2*TAG_W-1:TAG_W];
   assign rsp_old_local_page = rsp_tag_ff[TAG_W-1:0];

`ifndef NO_ASSERTIONS
   // The relink step always ends the request.
   a_relink_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RELINK |=> state_ff == ST_IDLE)
      else $error("relink step did not return to idle");

   // A new result comes only from an insert leaving the link step.
   a_result_from_insert: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LINK && ins_ff))
      else $error("result word without an insert");

   // The list ends never name the same slot.
   a_ends_differ: assert property (@(posedge clock) disable iff (reset)
      mru_ff != lru_ff)
      else $error("most and least recent slots coincide");

   // After a request the slot it worked on is most recent.
   a_slot_most_recent: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RELINK |=> mru_ff == $past(slot_ff))
      else $error("requested slot is not most recent");
`endif

endmodule
